// ===== rtl/ifs_pkg.sv =====
package ifs_pkg;

  localparam int FRAC = 12;
  localparam int PT_W = FRAC + 4;
  localparam int ACC_W = 34;
  localparam int MIN_W = ((2 ** FRAC) + 50) / 100;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_STEP  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_BORDER = 2'd2,
    CFG_SKIP   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MS_AD, MS_BC, MS_AX, MS_BY, MS_CX, MS_DY, MS_PX, MS_PY
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB
  } acc_op_e;

  typedef struct packed {
    logic     take_in;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     ld_commit;
    logic     start_pt;
    logic     tgt_calc;
    logic     cum_rd;
    logic     srch_upd;
    logic     coef_rd;
    logic     coef_ld;
    logic     nx_calc;
    logic     pt_upd;
    logic     pix_x;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       ld_ok;
    logic       no_rules;
    logic       srch_done;
    logic       skipping;
    logic       out_free;
  } dp_sts_t;

endpackage

// ===== rtl/ifs_chaos_game_step_unit.sv =====
// Chaos-game step engine for affine iterated function systems (Q3.12).
// Input channel (in_valid_i/in_ready_o) takes one word: opcode plus a rule's
// six coefficients and two random fractions. A load word stores a rule and
// extends the cumulative weight table, a start word places the point, a step
// word picks a rule by roulette and moves the point.
// Output channel (out_valid_o/out_ready_i) carries the pixel and rule index
// for each step past the configured skip count; other words give nothing.
// One word is worked on at a time. A skipped step runs a binary search over the
// weight table (one registered memory read per probe) and a shared 16x16
// multiplier used for the determinant, the affine map and the screen scaling;
// a step that produces a word also runs the screen scaling.
// A finished result sits in the output register; the next word is accepted
// meanwhile, and a following step holds in its last cycle until the output
// register is free. Configuration writes (cfg_we_i) are registered.
// Reset clears the rule count, weight total, point and step counter and
// restores the default screen setup; the rule memories need no clearing.
module ifs_chaos_game_step_unit
  import ifs_pkg::*;
#(
  parameter int MAX_RULES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic [7:0]         rule_index_i,
  input  logic signed [15:0] coef_a_i,
  input  logic signed [15:0] coef_b_i,
  input  logic signed [15:0] coef_c_i,
  input  logic signed [15:0] coef_d_i,
  input  logic signed [15:0] coef_e_i,
  input  logic signed [15:0] coef_f_i,
  input  logic [15:0]        rand_first_i,
  input  logic [15:0]        rand_second_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] pixel_x_o,
  output logic signed [15:0] pixel_y_o,
  output logic [7:0]         rule_chosen_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  ifs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ifs_dp #(
    .MAX_RULES (MAX_RULES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .opcode_i      (opcode_i),
    .rule_index_i  (rule_index_i),
    .coef_a_i      (coef_a_i),
    .coef_b_i      (coef_b_i),
    .coef_c_i      (coef_c_i),
    .coef_d_i      (coef_d_i),
    .coef_e_i      (coef_e_i),
    .coef_f_i      (coef_f_i),
    .rand_first_i  (rand_first_i),
    .rand_second_i (rand_second_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .rule_chosen_o (rule_chosen_o)
  );

endmodule

// ===== rtl/ifs_ctrl.sv =====
module ifs_ctrl
  import ifs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_DEC, ST_L_AD, ST_L_BC, ST_L_SUB, ST_L_COMMIT,
    ST_TGT, ST_S_CHK, ST_S_CMP, ST_S_RD, ST_S_LDC,
    ST_M_AX, ST_M_BY, ST_M_CX, ST_M_DY, ST_M_FY, ST_M_NY,
    ST_P_X, ST_P_Y, ST_P_XF, ST_P_YF
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.mul_sel = MS_AD;
    cmd_o.acc_op = ACC_HOLD;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take_in = 1'b1;
          state_d = ST_DEC;
        end
      end
      ST_DEC: begin
        state_d = ST_IDLE;
        case (opcode_e'(sts_i.opcode))
          OP_LOAD: if (sts_i.ld_ok) state_d = ST_L_AD;
          OP_START: cmd_o.start_pt = 1'b1;
          OP_STEP: if (!sts_i.no_rules) state_d = ST_TGT;
          default: state_d = ST_IDLE;
        endcase
      end
      ST_L_AD: begin
        cmd_o.mul_sel = MS_AD;
        state_d = ST_L_BC;
      end
      ST_L_BC: begin
        cmd_o.mul_sel = MS_BC;
        cmd_o.acc_op = ACC_LOAD;
        state_d = ST_L_SUB;
      end
      ST_L_SUB: begin
        cmd_o.acc_op = ACC_SUB;
        state_d = ST_L_COMMIT;
      end
      ST_L_COMMIT: begin
        cmd_o.ld_commit = 1'b1;
        state_d = ST_IDLE;
      end
      ST_TGT: begin
        cmd_o.tgt_calc = 1'b1;
        state_d = ST_S_CHK;
      end
      ST_S_CHK: begin
        if (sts_i.srch_done) begin
          state_d = ST_S_RD;
        end else begin
          cmd_o.cum_rd = 1'b1;
          state_d = ST_S_CMP;
        end
      end
      ST_S_CMP: begin
        cmd_o.srch_upd = 1'b1;
        state_d = ST_S_CHK;
      end
      ST_S_RD: begin
        cmd_o.coef_rd = 1'b1;
        state_d = ST_S_LDC;
      end
      ST_S_LDC: begin
        cmd_o.coef_ld = 1'b1;
        state_d = ST_M_AX;
      end
      ST_M_AX: begin
        cmd_o.mul_sel = MS_AX;
        state_d = ST_M_BY;
      end
      ST_M_BY: begin
        cmd_o.mul_sel = MS_BY;
        cmd_o.acc_op = ACC_LOAD;
        state_d = ST_M_CX;
      end
      ST_M_CX: begin
        cmd_o.mul_sel = MS_CX;
        cmd_o.acc_op = ACC_ADD;
        state_d = ST_M_DY;
      end
      ST_M_DY: begin
        cmd_o.mul_sel = MS_DY;
        cmd_o.nx_calc = 1'b1;
        cmd_o.acc_op = ACC_LOAD;
        state_d = ST_M_FY;
      end
      ST_M_FY: begin
        cmd_o.acc_op = ACC_ADD;
        state_d = ST_M_NY;
      end
      ST_M_NY: begin
        cmd_o.pt_upd = 1'b1;
        state_d = sts_i.skipping ? ST_IDLE : ST_P_X;
      end
      ST_P_X: begin
        cmd_o.mul_sel = MS_PX;
        state_d = ST_P_Y;
      end
      ST_P_Y: begin
        cmd_o.mul_sel = MS_PY;
        cmd_o.acc_op = ACC_LOAD;
        state_d = ST_P_XF;
      end
      ST_P_XF: begin
        cmd_o.pix_x = 1'b1;
        cmd_o.acc_op = ACC_LOAD;
        state_d = ST_P_YF;
      end
      ST_P_YF: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/ifs_dp.sv =====
module ifs_dp
  import ifs_pkg::*;
#(
  parameter int MAX_RULES = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  cmd_i,
  output dp_sts_t                  sts_o,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [15:0]              cfg_data_i,
  input  logic [1:0]               opcode_i,
  input  logic [7:0]               rule_index_i,
  input  logic signed [15:0]       coef_a_i,
  input  logic signed [15:0]       coef_b_i,
  input  logic signed [15:0]       coef_c_i,
  input  logic signed [15:0]       coef_d_i,
  input  logic signed [15:0]       coef_e_i,
  input  logic signed [15:0]       coef_f_i,
  input  logic [15:0]              rand_first_i,
  input  logic [15:0]              rand_second_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic signed [15:0]       pixel_x_o,
  output logic signed [15:0]       pixel_y_o,
  output logic [7:0]               rule_chosen_o
);

  localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CW = $clog2(MAX_RULES + 1);
  localparam int CMPW = (CW > 8) ? CW : 8;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(2 ** (FRAC - 1));

  function automatic logic signed [15:0] clamp16(input logic signed [ACC_W-1:0] v);
    if (v > ACC_W'(32767)) return 16'sh7fff;
    if (v < -ACC_W'(32768)) return -16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] fin_pt(input logic signed [ACC_W-1:0] s,
                                                input logic signed [15:0] off);
    logic signed [ACC_W-1:0] r;
    r = ((s + HALF) >>> FRAC) + ACC_W'(off);
    return clamp16(r);
  endfunction

  // config
  logic [12:0] width_q, height_q;
  logic [10:0] border_q;
  logic [15:0] skip_q;
  logic signed [15:0] boxm1_q;
  logic [13:0] xoff_q, yoff_q;
  logic [12:0] side;
  logic signed [14:0] box, xdiff, ydiff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd640;
      height_q <= 13'd480;
      border_q <= 11'd10;
      skip_q   <= 16'd50;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH:  width_q  <= cfg_data_i[12:0];
        CFG_HEIGHT: height_q <= cfg_data_i[12:0];
        CFG_BORDER: border_q <= cfg_data_i[10:0];
        CFG_SKIP:   skip_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    side  = (width_q < height_q) ? width_q : height_q;
    box   = $signed({2'b0, side}) - $signed({3'b0, border_q, 1'b0});
    xdiff = $signed({2'b0, width_q}) - box;
    ydiff = $signed({2'b0, height_q}) - box;
  end

  always_ff @(posedge clk_i) begin
    boxm1_q <= 16'(box) - 16'sd1;
    xoff_q  <= xdiff[14:1];
    yoff_q  <= ydiff[14:1];
  end

  // item registers
  logic [1:0]  op_q;
  logic [7:0]  idx_q;
  logic [15:0] rnd_q, rnd2_q;
  logic signed [15:0] a_q, b_q, c_q, d_q, e_q, f_q;
  logic [95:0] coef_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      op_q   <= opcode_i;
      idx_q  <= rule_index_i;
      rnd_q  <= rand_first_i;
      rnd2_q <= rand_second_i;
      a_q <= coef_a_i;
      b_q <= coef_b_i;
      c_q <= coef_c_i;
      d_q <= coef_d_i;
      e_q <= coef_e_i;
      f_q <= coef_f_i;
    end else if (cmd_i.coef_ld) begin
      {a_q, b_q, c_q, d_q, e_q, f_q} <= coef_rd_q;
    end
  end

  // point, counters
  logic signed [15:0] px_q, py_q, nx_q;
  logic [CW-1:0] count_q;
  logic [31:0] total_q;
  logic [15:0] steps_q;
  logic [31:0] target_q;
  logic [AW-1:0] lo_q, hi_q;
  logic [AW:0] mid_sum;
  logic [AW-1:0] mid;
  logic [31:0] cum_rd_q;
  logic signed [31:0] prod_q;
  logic signed [ACC_W-1:0] acc_q;

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid = mid_sum[AW:1];

  // rule store
  logic [95:0] coef_mem [MAX_RULES];
  logic [31:0] cum_mem [MAX_RULES];
  logic idx0;
  logic [AW-1:0] wa;
  logic signed [ACC_W-1:0] absd, wgt;
  logic [31:0] base;
  logic [34:0] sum;
  logic [31:0] sum_sat;

  always_comb begin
    idx0 = (idx_q == 8'd0);
    wa   = idx0 ? '0 : count_q[AW-1:0];
    absd = (acc_q < 0) ? -acc_q : acc_q;
    wgt  = absd >>> FRAC;
    if (wgt < ACC_W'(MIN_W)) wgt = ACC_W'(MIN_W);
    base = idx0 ? 32'd0 : total_q;
    sum  = 35'(base) + 35'(wgt);
    sum_sat = (sum[34:32] != 3'd0) ? 32'hffff_ffff : sum[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_commit) begin
      coef_mem[wa] <= {a_q, b_q, c_q, d_q, e_q, f_q};
      cum_mem[wa]  <= sum_sat;
    end
    if (cmd_i.cum_rd) cum_rd_q <= cum_mem[mid];
    if (cmd_i.coef_rd) coef_rd_q <= coef_mem[lo_q];
  end

  // multiplier and accumulator
  logic signed [15:0] mul_a, mul_b;

  always_comb begin
    case (cmd_i.mul_sel)
      MS_AD: begin mul_a = a_q; mul_b = d_q; end
      MS_BC: begin mul_a = b_q; mul_b = c_q; end
      MS_AX: begin mul_a = a_q; mul_b = px_q; end
      MS_BY: begin mul_a = b_q; mul_b = py_q; end
      MS_CX: begin mul_a = c_q; mul_b = px_q; end
      MS_DY: begin mul_a = d_q; mul_b = py_q; end
      MS_PX: begin mul_a = px_q; mul_b = boxm1_q; end
      MS_PY: begin mul_a = py_q; mul_b = boxm1_q; end
      default: begin mul_a = a_q; mul_b = d_q; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (cmd_i.acc_op)
      ACC_LOAD: acc_q <= ACC_W'(prod_q);
      ACC_ADD:  acc_q <= acc_q + ACC_W'(prod_q);
      ACC_SUB:  acc_q <= acc_q - ACC_W'(prod_q);
      default:  acc_q <= acc_q;
    endcase
    if (cmd_i.tgt_calc) target_q <= 32'((48'(rnd_q) * 48'(total_q)) >> 16);
    if (cmd_i.nx_calc) nx_q <= fin_pt(acc_q, e_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      total_q <= '0;
      px_q    <= '0;
      py_q    <= '0;
      steps_q <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
    end else begin
      if (cmd_i.ld_commit) begin
        count_q <= CW'(wa) + CW'(1);
        total_q <= sum_sat;
      end
      if (cmd_i.start_pt) begin
        px_q    <= 16'({4'b0, rnd_q[15:4]});
        py_q    <= 16'({4'b0, rnd2_q[15:4]});
        steps_q <= '0;
      end
      if (cmd_i.pt_upd) begin
        px_q <= nx_q;
        py_q <= fin_pt(acc_q, f_q);
        if (steps_q < skip_q) steps_q <= steps_q + 16'd1;
      end
      if (cmd_i.tgt_calc) begin
        lo_q <= '0;
        hi_q <= AW'(count_q - CW'(1));
      end
      if (cmd_i.srch_upd) begin
        if (cum_rd_q >= target_q) hi_q <= mid;
        else lo_q <= mid + AW'(1);
      end
    end
  end

  // output register
  logic signed [ACC_W-1:0] xs, ys;
  logic signed [15:0] xpix_q;
  logic out_valid_q;

  always_comb begin
    xs = (acc_q + $signed(ACC_W'({xoff_q, {FRAC{1'b0}}})) + HALF) >>> FRAC;
    ys = $signed(ACC_W'(height_q))
         - ((acc_q + $signed(ACC_W'({yoff_q, {FRAC{1'b0}}})) + HALF) >>> FRAC);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_x) xpix_q <= clamp16(xs);
    if (cmd_i.out_load) begin
      pixel_x_o     <= xpix_q;
      pixel_y_o     <= clamp16(ys);
      rule_chosen_o <= 8'(lo_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    sts_o.opcode    = op_q;
    sts_o.ld_ok     = idx0 || ((CMPW'(idx_q) == CMPW'(count_q)) &&
                               (count_q < CW'(MAX_RULES)));
    sts_o.no_rules  = (count_q == '0);
    sts_o.srch_done = (lo_q == hi_q);
    sts_o.skipping  = (steps_q < skip_q);
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

endmodule

// ===== tb/ifs_chaos_game_step_unit_tb.sv =====
module ifs_chaos_game_step_unit_tb;
  import ifs_pkg::*;

  typedef struct {
    opcode_e     op;
    logic [7:0]  idx;
    shortint     a, b, c, d, e, f;
    logic [15:0] r1, r2;
  } word_t;

  typedef struct {
    shortint    x, y;
    logic [7:0] rule;
  } pixel_t;

  typedef struct {
    word_t  w;
    bit     typed;
    pixel_t px;
  } dir_row_t;

  typedef struct {
    shortint a, b, c, d, e, f;
  } rule_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         opcode_i;
  logic [7:0]         rule_index_i;
  logic signed [15:0] coef_a_i, coef_b_i, coef_c_i, coef_d_i, coef_e_i, coef_f_i;
  logic [15:0]        rand_first_i, rand_second_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [15:0] pixel_x_o, pixel_y_o;
  logic [7:0]         rule_chosen_o;
  logic               cfg_we_i;
  logic [1:0]         cfg_idx_i;
  logic [15:0]        cfg_data_i;

  ifs_chaos_game_step_unit u_top (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ifs state mirror
  rule_t           rules[256];
  longint unsigned cum_weight[256];
  int unsigned     n_rules;
  longint unsigned weight_sum;
  longint          pt_x, pt_y;
  int unsigned     steps_done;
  int unsigned     scr_w, scr_h, scr_border, skip_cnt;

  pixel_t pending_pixels[$];
  int     errors = 0;
  bit     tx_idle_on, rx_idle_on, hold_req;

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint map_coord(longint p, longint q, longint u, longint v,
                                       longint off);
    longint s;
    s = p * u + q * v + (longint'(1) <<< (FRAC - 1));
    return sat16((s >>> FRAC) + off);
  endfunction

  task automatic predict_word(input word_t w, output bit emit, output pixel_t px);
    longint          det, box, xoff, yoff, nx, ny;
    longint unsigned wt, tgt;
    int unsigned     j;
    emit = 0;
    px = '{0, 0, 0};
    case (w.op)
      OP_LOAD: begin
        if (w.idx == 0) begin
          n_rules = 0;
          weight_sum = 0;
        end
        if (w.idx == n_rules && n_rules < 256) begin
          det = longint'(w.a) * w.d - longint'(w.b) * w.c;
          if (det < 0) det = -det;
          wt = longint'(det) >> FRAC;
          if (wt < MIN_W) wt = MIN_W;
          wt = wt + weight_sum;
          if (wt > 64'hFFFF_FFFF) wt = 64'hFFFF_FFFF;
          rules[w.idx] = '{w.a, w.b, w.c, w.d, w.e, w.f};
          cum_weight[w.idx] = wt;
          weight_sum = wt;
          n_rules = w.idx + 1;
        end
      end
      OP_START: begin
        pt_x = w.r1 >> (16 - FRAC);
        pt_y = w.r2 >> (16 - FRAC);
        steps_done = 0;
      end
      OP_STEP: begin
        if (n_rules != 0) begin
          tgt = (longint'(w.r1) * weight_sum) >> 16;
          j = 0;
          while (j + 1 < n_rules && cum_weight[j] < tgt) j++;
          nx = map_coord(pt_x, pt_y, rules[j].a, rules[j].b, rules[j].e);
          ny = map_coord(pt_x, pt_y, rules[j].c, rules[j].d, rules[j].f);
          pt_x = nx;
          pt_y = ny;
          if (steps_done < skip_cnt) begin
            steps_done++;
          end else begin
            box = longint'(scr_w < scr_h ? scr_w : scr_h) - 2 * longint'(scr_border);
            xoff = (longint'(scr_w) - box) / 2;
            yoff = (longint'(scr_h) - box) / 2;
            px.x = shortint'(sat16((nx * (box - 1) + (xoff <<< FRAC)
                                    + (longint'(1) <<< (FRAC - 1))) >>> FRAC));
            px.y = shortint'(sat16(longint'(scr_h) - ((ny * (box - 1) + (yoff <<< FRAC)
                                    + (longint'(1) <<< (FRAC - 1))) >>> FRAC)));
            px.rule = j[7:0];
            emit = 1;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_word(input word_t w, input bit typed, input pixel_t typed_px);
    int     gap;
    bit     emit;
    pixel_t px;
    gap = tx_idle_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= w.op;
    rule_index_i  <= w.idx;
    coef_a_i      <= w.a;
    coef_b_i      <= w.b;
    coef_c_i      <= w.c;
    coef_d_i      <= w.d;
    coef_e_i      <= w.e;
    coef_f_i      <= w.f;
    rand_first_i  <= w.r1;
    rand_second_i <= w.r2;
    do @(posedge clk_i); while (!in_ready_o);
    predict_word(w, emit, px);
    if (emit) pending_pixels.push_back(typed ? typed_px : px);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_screen(input int unsigned w, h, bd, sk);
    in_valid_i <= 1'b0;
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_WIDTH;
    cfg_data_i <= 16'(w);
    @(posedge clk_i);
    cfg_idx_i <= CFG_HEIGHT;
    cfg_data_i <= 16'(h);
    @(posedge clk_i);
    cfg_idx_i <= CFG_BORDER;
    cfg_data_i <= 16'(bd);
    @(posedge clk_i);
    cfg_idx_i <= CFG_SKIP;
    cfg_data_i <= 16'(sk);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    scr_w = w;
    scr_h = h;
    scr_border = bd;
    skip_cnt = sk;
  endtask

  function automatic shortint rand_coef();
    if ($urandom_range(0, 3) == 0) return shortint'($urandom_range(0, 65535));
    return shortint'(int'($urandom_range(0, 8191)) - 4096);
  endfunction

  function automatic word_t rand_word(opcode_e op, logic [7:0] idx);
    word_t w;
    w.op = op;
    w.idx = idx;
    w.a = rand_coef();
    w.b = rand_coef();
    w.c = rand_coef();
    w.d = rand_coef();
    w.e = rand_coef();
    w.f = rand_coef();
    w.r1 = 16'($urandom_range(0, 65535));
    w.r2 = 16'($urandom_range(0, 65535));
    return w;
  endfunction

  task automatic load_set(input int k);
    for (int i = 0; i < k; i++) send_word(rand_word(OP_LOAD, 8'(i)), 0, '{0, 0, 0});
    send_word(rand_word(OP_START, 0), 0, '{0, 0, 0});
  endtask

  task automatic random_phase(input int n, input int max_set);
    int pick;
    load_set($urandom_range(1, max_set));
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) load_set($urandom_range(1, max_set));
      else if (pick < 10) send_word(rand_word(OP_START, 0), 0, '{0, 0, 0});
      else if (pick < 12)
        send_word(rand_word(OP_NONE, 8'($urandom_range(0, 255))), 0, '{0, 0, 0});
      else if (pick < 15)
        send_word(rand_word(OP_LOAD, 8'($urandom_range(1, 255))), 0, '{0, 0, 0});
      else send_word(rand_word(OP_STEP, 0), 0, '{0, 0, 0});
    end
  endtask

  dir_row_t dir_rows[$];

  initial begin
    in_valid_i = 1'b0;
    opcode_i = '0;
    rule_index_i = '0;
    coef_a_i = '0;
    coef_b_i = '0;
    coef_c_i = '0;
    coef_d_i = '0;
    coef_e_i = '0;
    coef_f_i = '0;
    rand_first_i = '0;
    rand_second_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_WIDTH;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    hold_req = 0;
    tx_idle_on = 1;
    rx_idle_on = 1;
    n_rules = 0;
    weight_sum = 0;
    pt_x = 0;
    pt_y = 0;
    steps_done = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default screen, no skip
    dir_rows = '{
      '{'{OP_STEP, 0, 0, 0, 0, 0, 0, 0, 16'h1234, 0}, 0, '{0, 0, 0}},
      '{'{OP_LOAD, 0, 4096, 0, 0, 4096, 0, 0, 0, 0}, 0, '{0, 0, 0}},
      '{'{OP_START, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 0, '{0, 0, 0}},
      '{'{OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, '{90, 470, 0}},
      '{'{OP_NONE, 8'hFF, -1, -1, -1, -1, -1, -1, 16'hFFFF, 16'hFFFF}, 0, '{0, 0, 0}},
      '{'{OP_LOAD, 5, 4096, 0, 0, 4096, 0, 0, 0, 0}, 0, '{0, 0, 0}},
      '{'{OP_LOAD, 1, -32768, 32767, -32768, -32768, 32767, -32768, 0, 0}, 0, '{0, 0, 0}},
      '{'{OP_START, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF}, 0, '{0, 0, 0}},
      '{'{OP_STEP, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF, 0}, 0, '{0, 0, 0}},
      '{'{OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF}, 0, '{0, 0, 0}},
      '{'{OP_LOAD, 2, 0, 0, 0, 0, 0, 0, 0, 0}, 0, '{0, 0, 0}},
      '{'{OP_LOAD, 3, 32767, -32768, 32767, 32767, 0, 0, 0, 0}, 0, '{0, 0, 0}},
      '{'{OP_STEP, 0, 0, 0, 0, 0, 0, 0, 16'h8000, 0}, 0, '{0, 0, 0}},
      '{'{OP_STEP, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF, 0}, 0, '{0, 0, 0}},
      '{'{OP_LOAD, 0, 2048, 0, 0, 2048, 2048, 0, 0, 0}, 0, '{0, 0, 0}},
      '{'{OP_START, 0, 0, 0, 0, 0, 0, 0, 16'h8000, 16'h8000}, 0, '{0, 0, 0}},
      '{'{OP_STEP, 0, 0, 0, 0, 0, 0, 0, 16'h1234, 0}, 0, '{0, 0, 0}},
      '{'{OP_STEP, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF, 0}, 0, '{0, 0, 0}}
    };
    scr_w = 640;
    scr_h = 480;
    scr_border = 10;
    skip_cnt = 50;
    set_screen(640, 480, 10, 0);
    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].px);

    wait_idle();
    set_screen(640, 480, 10, 50);
    random_phase(30, 4);

    wait_idle();
    set_screen(4096, 4096, 0, 3);
    tx_idle_on = 0;
    random_phase(30, 6);

    wait_idle();
    set_screen(1, 1, 2047, 0);
    tx_idle_on = 1;
    rx_idle_on = 0;
    random_phase(15, 3);

    wait_idle();
    set_screen(4096, 1, 0, 65535);
    rx_idle_on = 1;
    random_phase(10, 3);

    wait_idle();
    set_screen(800, 600, 100, 5);
    tx_idle_on = 0;
    hold_req = 1;
    random_phase(30, 8);

    wait_idle();
    set_screen(333, 4096, 2047, 0);
    tx_idle_on = 1;
    random_phase(15, 5);

    // full rule table
    wait_idle();
    set_screen(640, 480, 10, 0);
    load_set(256);
    for (int i = 0; i < 20; i++) send_word(rand_word(OP_STEP, 0), 0, '{0, 0, 0});
    send_word(rand_word(OP_LOAD, 8'hAA), 0, '{0, 0, 0});

    in_valid_i <= 1'b0;
    wait_idle();
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int n;
    out_ready_i = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        n = 300;
        hold_req = 0;
      end else begin
        n = rx_idle_on ? $urandom_range(0, 12) : 0;
      end
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    pixel_t exp_px;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected word x=%0d y=%0d rule=%0d", $time, pixel_x_o, pixel_y_o,
                 rule_chosen_o);
        errors++;
      end else begin
        exp_px = pending_pixels.pop_front();
        if (pixel_x_o !== exp_px.x) begin
          $display("%0t: pixel_x expected %0d actual %0d", $time, exp_px.x, pixel_x_o);
          errors++;
        end
        if (pixel_y_o !== exp_px.y) begin
          $display("%0t: pixel_y expected %0d actual %0d", $time, exp_px.y, pixel_y_o);
          errors++;
        end
        if (rule_chosen_o !== exp_px.rule) begin
          $display("%0t: rule_chosen expected %0d actual %0d", $time, exp_px.rule,
                   rule_chosen_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
